### src/pbg_pkg.sv
// Package for the battery gauge snapshot decoder.
// Status codes, scaling constants and the charge curve. No dependencies.
`default_nettype none

package pbg_pkg;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NOT_ENABLED = 2'd1,
    STATUS_BUS_FAIL    = 2'd2
  } result_status_e;

  localparam int unsigned CurvePoints = 10;
  localparam int unsigned CurveSegs   = CurvePoints - 1;

  localparam logic [7:0]  StatusUsbMask  = 8'h20;
  localparam logic [7:0]  StatusChgMask  = 8'h04;
  localparam logic [3:0]  BatVoltScale   = 4'd11;
  localparam logic [4:0]  BusVoltScale   = 5'd17;
  // floor(x / 10) == (x * DivTenRecip) >> DivTenShift for x < 81920
  localparam logic [15:0] DivTenRecip    = 16'd52429;
  localparam int unsigned DivTenShift    = 19;
  // per-segment division by the segment width, ceil(2^20 / width)
  localparam int unsigned SegRecipShift  = 20;
  localparam logic [6:0]  PercentFull    = 7'd100;

  localparam logic [12:0] CURVE_MV [CurvePoints] = '{
    13'd3300, 13'd3400, 13'd3500, 13'd3600, 13'd3680,
    13'd3750, 13'd3850, 13'd3950, 13'd4050, 13'd4150
  };
  localparam logic [6:0] CURVE_PCT [CurvePoints] = '{
    7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd45, 7'd60, 7'd75, 7'd90, 7'd100
  };
  localparam logic [3:0] SEG_DPCT [CurveSegs] = '{
    4'd5, 4'd5, 4'd10, 4'd10, 4'd15, 4'd15, 4'd15, 4'd15, 4'd10
  };
  localparam logic [14:0] SEG_RECIP [CurveSegs] = '{
    15'd10486, 15'd10486, 15'd10486, 15'd13108, 15'd14980,
    15'd10486, 15'd10486, 15'd10486, 15'd10486
  };

endpackage

`default_nettype wire

### src/pmic_adc_battery_gauge.sv
// Battery gauge snapshot decoder: one ADC register snapshot in, one decoded result out.
// Four-stage pipeline with a per-stage valid/ready chain. Depends on pbg_pkg.
//
// Each transfer on the input stream is one register snapshot; each produces
// exactly one result transfer, in order. While the output is not stalled, the
// pipeline takes one snapshot every cycle: stage 1 forms the codes and the
// x11/x17 products, stage 2 divides by ten with a reciprocal multiply and
// halves the current, stage 3 finds the curve segment and scales its offset,
// stage 4 divides by the segment width and holds the result. A stalled output
// holds its stage; empty stages upstream keep accepting until the pipeline is
// full. The enable register is sampled when a snapshot is accepted; the user
// must write it only while the block is idle; the block does not enforce it.
`default_nettype none

module pmic_adc_battery_gauge (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write: monitor_enabled
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,
  // snapshot stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata, from bit 0: status_byte, batt_volt_high, batt_volt_low,
  // charge_cur_high, charge_cur_low, discharge_cur_high, discharge_cur_low,
  // bus_volt_high, bus_volt_low (8 bits each)
  input  wire logic [71:0] s_axis_tdata,
  // tuser: bus_error
  input  wire logic [0:0]  s_axis_tuser,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata, from bit 0: battery_millivolts (13), battery_milliamps (13, signed),
  // bus_millivolts (13), usb_present (1), is_charging (1), charge_percent (7)
  output logic [47:0]      m_axis_tdata,
  // tuser: result_status (2)
  output logic [1:0]       m_axis_tuser
);
  import pbg_pkg::*;

  logic enabled_q;

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1
  result_status_e st1_q;
  logic           usb1_q, chg1_q;
  logic [15:0]    bat_x11_q;
  logic [16:0]    bus_x17_q;
  logic [13:0]    cur_diff_q;
  // stage 2
  result_status_e st2_q;
  logic           usb2_q, chg2_q;
  logic [12:0]    bat_mv2_q, bus_mv2_q, ma2_q;
  // stage 3
  result_status_e st3_q;
  logic           usb3_q, chg3_q;
  logic [12:0]    bat_mv3_q, bus_mv3_q, ma3_q;
  logic [10:0]    num3_q;
  logic [14:0]    recip3_q;
  logic [6:0]     base3_q;
  // stage 4 (output)
  result_status_e st4_q;
  logic           usb4_q, chg4_q;
  logic [12:0]    bat_mv4_q, bus_mv4_q, ma4_q;
  logic [6:0]     pct4_q;

  // stage 1 combinational
  result_status_e st1_d;
  logic [11:0]    bat_code, bus_code;
  logic [12:0]    chg_code, dis_code;
  logic [7:0]     status_byte;
  // stage 2 combinational
  logic [31:0]    bat_prod;
  logic [32:0]    bus_prod;
  logic [13:0]    cur_adj;
  // stage 3 combinational
  logic [3:0]     seg;
  logic [12:0]    seg_off;
  logic [10:0]    num3_d;
  logic [6:0]     base3_d;
  // stage 4 combinational
  logic [25:0]    q_prod;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
    end else if (cfg_valid_i) begin
      enabled_q <= cfg_data_i;
    end
  end

  assign rdy4 = m_axis_tready || !v4_q;
  assign rdy3 = rdy4 || !v3_q;
  assign rdy2 = rdy3 || !v2_q;
  assign rdy1 = rdy2 || !v1_q;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: status, codes gated to zero on failure, products
  always_comb begin
    if (!enabled_q) begin
      st1_d = STATUS_NOT_ENABLED;
    end else if (s_axis_tuser[0]) begin
      st1_d = STATUS_BUS_FAIL;
    end else begin
      st1_d = STATUS_OK;
    end
    if (st1_d == STATUS_OK) begin
      status_byte = s_axis_tdata[7:0];
      bat_code    = {s_axis_tdata[15:8], s_axis_tdata[19:16]};
      chg_code    = {s_axis_tdata[31:24], s_axis_tdata[36:32]};
      dis_code    = {s_axis_tdata[47:40], s_axis_tdata[52:48]};
      bus_code    = {s_axis_tdata[63:56], s_axis_tdata[67:64]};
    end else begin
      status_byte = '0;
      bat_code    = '0;
      chg_code    = '0;
      dis_code    = '0;
      bus_code    = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      st1_q      <= st1_d;
      usb1_q     <= |(status_byte & StatusUsbMask);
      chg1_q     <= |(status_byte & StatusChgMask);
      bat_x11_q  <= {4'd0, bat_code} * {12'd0, BatVoltScale};
      bus_x17_q  <= {5'd0, bus_code} * {12'd0, BusVoltScale};
      cur_diff_q <= {1'b0, chg_code} - {1'b0, dis_code};
    end
  end

  // stage 2: divide by ten, halve current toward zero
  assign bat_prod = {16'd0, bat_x11_q} * {16'd0, DivTenRecip};
  assign bus_prod = {16'd0, bus_x17_q} * {17'd0, DivTenRecip};
  assign cur_adj  = cur_diff_q + {13'd0, cur_diff_q[13]};

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      st2_q     <= st1_q;
      usb2_q    <= usb1_q;
      chg2_q    <= chg1_q;
      bat_mv2_q <= bat_prod[DivTenShift +: 13];
      bus_mv2_q <= bus_prod[DivTenShift +: 13];
      ma2_q     <= cur_adj[13:1];
    end
  end

  // stage 3: curve segment and scaled offset
  always_comb begin
    seg = '0;
    for (int j = 1; j < CurveSegs; j++) begin
      if (bat_mv2_q >= CURVE_MV[j]) seg = 4'(j);
    end
    seg_off = bat_mv2_q - CURVE_MV[seg];
    if (bat_mv2_q <= CURVE_MV[0]) begin
      base3_d = CURVE_PCT[0];
      num3_d  = '0;
    end else if (bat_mv2_q >= CURVE_MV[CurvePoints-1]) begin
      base3_d = PercentFull;
      num3_d  = '0;
    end else begin
      base3_d = CURVE_PCT[seg];
      num3_d  = {4'd0, seg_off[6:0]} * {7'd0, SEG_DPCT[seg]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      st3_q     <= st2_q;
      usb3_q    <= usb2_q;
      chg3_q    <= chg2_q;
      bat_mv3_q <= bat_mv2_q;
      bus_mv3_q <= bus_mv2_q;
      ma3_q     <= ma2_q;
      num3_q    <= num3_d;
      recip3_q  <= SEG_RECIP[seg];
      base3_q   <= base3_d;
    end
  end

  // stage 4: divide by segment width, add base percent
  assign q_prod = {15'd0, num3_q} * {11'd0, recip3_q};

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      st4_q     <= st3_q;
      usb4_q    <= usb3_q;
      chg4_q    <= chg3_q;
      bat_mv4_q <= bat_mv3_q;
      bus_mv4_q <= bus_mv3_q;
      ma4_q     <= ma3_q;
      pct4_q    <= base3_q + {1'b0, q_prod[SegRecipShift +: 6]};
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tuser  = st4_q;
  assign m_axis_tdata  = {pct4_q, chg4_q, usb4_q, bus_mv4_q, ma4_q, bat_mv4_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> (m_axis_tdata == '0))
    else $error("failed status with nonzero result fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pct4_q <= PercentFull))
    else $error("charge percent above full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (bat_mv2_q <= 13'd4504) && (bus_mv2_q <= 13'd6961))
    else $error("scaled voltage out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !rdy2 |=> v1_q && $stable(bat_x11_q) && $stable(cur_diff_q))
    else $error("stage 1 lost data under stall");

endmodule

`default_nettype wire
